@@ sv/kpc_pkg.sv @@
`default_nettype none

package kpc_pkg;

    // Fixed sizes of the item fields.
    localparam int MAX_KEYS      = 8;
    localparam int KEY_INDEX_W   = 3;
    localparam int TIME_W        = 32;
    localparam int KEY_COUNT_W   = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERY_LONG_TIME    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL_MASK = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_COUNT         = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0]      DEBOUNCE_TIME_RST  = 32'd20;
    localparam logic [TIME_W-1:0]      LONG_TIME_RST      = 32'd1000;
    localparam logic [TIME_W-1:0]      VERY_LONG_TIME_RST = 32'd5000;
    localparam logic [MAX_KEYS-1:0]    ACTIVE_LEVEL_RST   = 8'd0;
    localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST      = 4'd8;

    typedef enum logic [2:0] {
        PH_RELEASED  = 3'd0,
        PH_CONFIRM   = 3'd1,
        PH_CONFIRMED = 3'd2,
        PH_LONG      = 3'd3,
        PH_VERY_LONG = 3'd4
    } key_phase_t;

    typedef enum logic [1:0] {
        KIND_SHORT     = 2'd0,
        KIND_LONG      = 2'd1,
        KIND_VERY_LONG = 2'd2
    } press_kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]      debounce_time;
        logic [TIME_W-1:0]      long_time;
        logic [TIME_W-1:0]      very_long_time;
        logic [MAX_KEYS-1:0]    active_level_mask;
        logic [KEY_COUNT_W-1:0] key_count;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        press_kind_t kind;
    } lane_ev_t;

endpackage

`default_nettype wire

@@ sv/kpc_key_lane.sv @@
`default_nettype none

// Debounce and press-length state machine of one key.
module kpc_key_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        active,
    input  wire logic                        step,
    input  wire logic                        pressed,
    input  wire logic [kpc_pkg::TIME_W-1:0]  now_time,
    input  wire kpc_pkg::cfg_t               cfg,
    output kpc_pkg::lane_ev_t                lane_ev
);

    kpc_pkg::key_phase_t             phase_reg;
    kpc_pkg::key_phase_t             phase_next;
    logic [kpc_pkg::TIME_W-1:0]      start_reg;
    logic [kpc_pkg::TIME_W-1:0]      start_next;
    logic [kpc_pkg::TIME_W-1:0]      elapsed;
    kpc_pkg::lane_ev_t               ev_raw;

    // Elapsed time wraps modulo 2^32 like the timestamp.
    assign elapsed = now_time - start_reg;

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        case (phase_reg)
            kpc_pkg::PH_RELEASED:
            begin
                if (pressed)
                begin
                    phase_next = kpc_pkg::PH_CONFIRM;
                    start_next = now_time;
                end
            end
            kpc_pkg::PH_CONFIRM:
            begin
                if (!pressed)
                    phase_next = kpc_pkg::PH_RELEASED;
                else if (elapsed >= cfg.debounce_time)
                    phase_next = kpc_pkg::PH_CONFIRMED;
            end
            kpc_pkg::PH_CONFIRMED:
            begin
                if (!pressed)
                    phase_next = kpc_pkg::PH_RELEASED;
                else if (elapsed >= cfg.long_time)
                    phase_next = kpc_pkg::PH_LONG;
            end
            kpc_pkg::PH_LONG:
            begin
                if (!pressed)
                    phase_next = kpc_pkg::PH_RELEASED;
                else if (elapsed >= cfg.very_long_time)
                    phase_next = kpc_pkg::PH_VERY_LONG;
            end
            kpc_pkg::PH_VERY_LONG:
            begin
                if (!pressed)
                    phase_next = kpc_pkg::PH_RELEASED;
            end
            default:
            begin
                phase_next = kpc_pkg::PH_RELEASED;
                start_next = now_time;
            end
        endcase
    end

    always_comb
    begin
        ev_raw.valid = 1'b0;
        ev_raw.kind  = kpc_pkg::KIND_SHORT;
        case (phase_reg)
            kpc_pkg::PH_CONFIRMED:
            begin
                if (!pressed)
                begin
                    ev_raw.valid = 1'b1;
                    ev_raw.kind  = kpc_pkg::KIND_SHORT;
                end
                else if (elapsed >= cfg.long_time)
                begin
                    ev_raw.valid = 1'b1;
                    ev_raw.kind  = kpc_pkg::KIND_LONG;
                end
            end
            kpc_pkg::PH_LONG:
            begin
                if (pressed && (elapsed >= cfg.very_long_time))
                begin
                    ev_raw.valid = 1'b1;
                    ev_raw.kind  = kpc_pkg::KIND_VERY_LONG;
                end
            end
            default:
            begin
                ev_raw.valid = 1'b0;
            end
        endcase
    end

    assign lane_ev.valid = ev_raw.valid & active;
    assign lane_ev.kind  = ev_raw.kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kpc_pkg::PH_RELEASED;
            start_reg <= '0;
        end
        else if (step && active)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/kpc_event_queue.sv @@
`default_nettype none

// Holds the events of one scan tick and hands them out lowest key first.
module kpc_event_queue (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire logic [kpc_pkg::MAX_KEYS-1:0]         load_mask,
    input  wire kpc_pkg::press_kind_t [kpc_pkg::MAX_KEYS-1:0] load_kind,
    output logic                                      can_load,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [kpc_pkg::KEY_INDEX_W-1:0]           key_index,
    output logic [1:0]                                press_kind,
    output logic                                      last_event
);

    logic [kpc_pkg::MAX_KEYS-1:0]                 mask_reg;
    logic [kpc_pkg::MAX_KEYS-1:0]                 mask_next;
    logic [kpc_pkg::MAX_KEYS-1:0]                 mask_rest;
    kpc_pkg::press_kind_t [kpc_pkg::MAX_KEYS-1:0] kind_reg;
    logic [kpc_pkg::KEY_INDEX_W-1:0]              low_idx;
    logic                                         take;

    // Lowest pending key.
    always_comb
    begin
        low_idx = '0;
        for (int i = kpc_pkg::MAX_KEYS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                low_idx = kpc_pkg::KEY_INDEX_W'(i);
        end
    end

    assign mask_rest  = mask_reg & (mask_reg - kpc_pkg::MAX_KEYS'(1));
    assign out_valid  = |mask_reg;
    assign key_index  = low_idx;
    assign press_kind = kind_reg[low_idx];
    assign last_event = (mask_rest == '0);
    assign take       = out_valid && out_ready;
    assign can_load   = !out_valid || (take && last_event);

    always_comb
    begin
        if (load)
            mask_next = load_mask;
        else if (take)
            mask_next = mask_rest;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            kind_reg <= load_kind;
    end

endmodule

`default_nettype wire

@@ sv/key_press_classifier_top.sv @@
// Key press classifier: debounces up to eight buttons and reports short,
// long and very long presses.
// Input channel: in_valid/in_ready carry one scan tick per item, with the raw
// key levels and a wrapping millisecond timestamp. Output channel:
// out_valid/out_ready carry one event per item (key, kind, last-of-tick mark).
// The configuration port (cfg_write, cfg_index, cfg_data) writes a register
// and must only be used while the block is idle.
// A tick passes the input register, then its events are loaded into the
// event queue, which offers them. A tick causing n events occupies the
// queue until all n are taken; the queue drains one event a cycle while
// out_ready is high, at most eight events per tick. The next tick is taken
// into the input register while events of the previous one still wait;
// its keys update once the queue can take its events, or at once if none.
// Reset puts every key in the released state with a zero press start and
// loads the documented default thresholds. When the receiver stalls, the
// current event is held, the queue fills, and in_ready drops once the input
// register holds a tick whose events cannot be queued yet.
`default_nettype none

module key_press_classifier_top #(
    parameter int NUM_KEYS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [kpc_pkg::MAX_KEYS-1:0]      key_levels,
    input  wire logic [kpc_pkg::TIME_W-1:0]        now_time,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [kpc_pkg::KEY_INDEX_W-1:0]        key_index,
    output logic [1:0]                             press_kind,
    output logic                                   last_event,
    input  wire logic                              cfg_write,
    input  wire logic [kpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [kpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Only the first eight keys can ever be scanned, whatever NUM_KEYS is.
    localparam int KEYS_USED = (NUM_KEYS < kpc_pkg::MAX_KEYS) ? NUM_KEYS
                                                              : kpc_pkg::MAX_KEYS;

    kpc_pkg::cfg_t                                cfg_reg;
    logic                                         in_valid_reg;
    logic [kpc_pkg::MAX_KEYS-1:0]                 levels_reg;
    logic [kpc_pkg::TIME_W-1:0]                   now_reg;
    logic                                         fire;
    logic                                         can_load;
    logic [kpc_pkg::MAX_KEYS-1:0]                 ev_mask;
    kpc_pkg::press_kind_t [kpc_pkg::MAX_KEYS-1:0] ev_kind;

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time     <= kpc_pkg::DEBOUNCE_TIME_RST;
            cfg_reg.long_time         <= kpc_pkg::LONG_TIME_RST;
            cfg_reg.very_long_time    <= kpc_pkg::VERY_LONG_TIME_RST;
            cfg_reg.active_level_mask <= kpc_pkg::ACTIVE_LEVEL_RST;
            cfg_reg.key_count         <= kpc_pkg::KEY_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                kpc_pkg::REG_DEBOUNCE_TIME:
                    cfg_reg.debounce_time <= cfg_data;
                kpc_pkg::REG_LONG_TIME:
                    cfg_reg.long_time <= cfg_data;
                kpc_pkg::REG_VERY_LONG_TIME:
                    cfg_reg.very_long_time <= cfg_data;
                kpc_pkg::REG_ACTIVE_LEVEL_MASK:
                    cfg_reg.active_level_mask <= cfg_data[kpc_pkg::MAX_KEYS-1:0];
                kpc_pkg::REG_KEY_COUNT:
                    cfg_reg.key_count <= cfg_data[kpc_pkg::KEY_COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // A tick in the input register is processed when its events, if any,
    // can go into the event queue.
    assign fire     = in_valid_reg && ((ev_mask == '0) || can_load);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            levels_reg <= key_levels;
            now_reg    <= now_time;
        end
    end

    // One state machine per used key; the active ones all step on the same tick.
    for (genvar g = 0; g < kpc_pkg::MAX_KEYS; g++)
    begin : g_key
        if (g < KEYS_USED)
        begin : g_lane
            kpc_pkg::lane_ev_t lane_ev;
            logic              active;

            assign active = (kpc_pkg::KEY_COUNT_W'(g) < cfg_reg.key_count);

            kpc_key_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active),
                .step     (fire),
                .pressed  (~(levels_reg[g] ^ cfg_reg.active_level_mask[g])),
                .now_time (now_reg),
                .cfg      (cfg_reg),
                .lane_ev  (lane_ev)
            );

            assign ev_mask[g] = lane_ev.valid;
            assign ev_kind[g] = lane_ev.kind;
        end
        else
        begin : g_unused
            assign ev_mask[g] = 1'b0;
            assign ev_kind[g] = kpc_pkg::KIND_SHORT;
        end
    end

    kpc_event_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && (ev_mask != '0)),
        .load_mask  (ev_mask),
        .load_kind  (ev_kind),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .press_kind (press_kind),
        .last_event (last_event)
    );

endmodule

`default_nettype wire
